// ----- hdl/hsc_pkg.sv -----
// Package: types and constants for the hybrid set container.
`timescale 1ns / 1ps
package hsc_pkg;
  localparam int ArrayLimit  = 4096;
  localparam int ArrayDepth  = 4096;
  localparam int BitmapWords = 1024;
  localparam int WordBits    = 64;
  localparam int AW = $clog2(ArrayDepth);
  localparam int WW = $clog2(BitmapWords);
  localparam int BW = $clog2(WordBits);
  localparam int CW = 17;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic          was_present;
    logic          bitmap_mode;
    logic [CW-1:0] member_total;
  } out_item_t;
endpackage

// ----- hdl/hsc_fifo.sv -----
// Small two-entry queue used between the input port, the back part and the result port.
`timescale 1ns / 1ps
module hsc_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp] <= din;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        wp <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    full && !(pop && !empty) |=> full)
    else $error("full queue lost an entry");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop && !(push && !full) |=> cnt == $past(cnt))
    else $error("queue count changed while idle");
`endif
endmodule

// ----- hdl/hsc_engine.sv -----
// Back part: sorted array search, insert shift, bitmap test/set and conversion.
`timescale 1ns / 1ps
module hsc_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  hsc_pkg::in_item_t  req,
  output logic               req_take,
  output logic               res_valid,
  output hsc_pkg::out_item_t res,
  input  logic               res_full
);
  import hsc_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SRD    = 4'd2;
  localparam logic [3:0] S_SCMP   = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_SHRD   = 4'd5;
  localparam logic [3:0] S_SHWR   = 4'd6;
  localparam logic [3:0] S_CVRD   = 4'd7;
  localparam logic [3:0] S_CVBR   = 4'd8;
  localparam logic [3:0] S_CVBW   = 4'd9;
  localparam logic [3:0] S_BRD    = 4'd10;
  localparam logic [3:0] S_BWR    = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;
  localparam logic [3:0] S_DEC    = 4'd13;

  logic [3:0]        state;
  logic [15:0]       arr [ArrayDepth];
  logic [15:0]       arr_q;
  logic [AW-1:0]     arr_ra;
  logic              arr_we;
  logic [AW-1:0]     arr_wa;
  logic [15:0]       arr_wd;
  logic [WordBits-1:0] bmp [BitmapWords];
  logic [WordBits-1:0] bmp_q;
  logic [WW-1:0]     bmp_ra;
  logic              bmp_we;
  logic [WW-1:0]     bmp_wa;
  logic [WordBits-1:0] bmp_wd;

  logic              mode;
  logic [CW-1:0]     count;
  logic              cmd;
  logic [15:0]       val;
  logic [AW:0]       lo;
  logic [AW:0]       hi;
  logic [AW:0]       idx;
  logic [AW:0]       mid;
  logic              present;
  logic [15:0]       cv_val;
  logic              hit;

  assign mid = (lo + hi) >> 1;
  assign hit = (count > CW'(lo)) && (arr_q == val);
  assign req_take = (state == S_IDLE) && req_valid;
  assign res_valid = (state == S_OUT) && !res_full;
  assign res.was_present  = present;
  assign res.bitmap_mode  = mode;
  assign res.member_total = count;

  always_ff @(posedge clk) begin
    if (arr_we) begin
      arr[arr_wa] <= arr_wd;
    end
    arr_q <= arr[arr_ra];
    if (bmp_we) begin
      bmp[bmp_wa] <= bmp_wd;
    end
    bmp_q <= bmp[bmp_ra];
  end

  always_comb begin
    arr_ra = mid[AW-1:0];
    arr_we = 1'b0;
    arr_wa = idx[AW-1:0];
    arr_wd = arr_q;
    bmp_ra = val[15:BW];
    bmp_we = 1'b0;
    bmp_wa = val[15:BW];
    bmp_wd = bmp_q | (WordBits'(1) << val[BW-1:0]);
    case (state)
      S_CLEAR: begin
        bmp_we = 1'b1;
        bmp_wa = idx[WW-1:0];
        bmp_wd = '0;
      end
      S_IDLE: begin
        bmp_ra = req.value[15:BW];
      end
      S_CHK: arr_ra = lo[AW-1:0];
      S_SHRD: arr_ra = AW'(idx - 1'b1);
      S_SHWR: begin
        arr_we = 1'b1;
        if (idx == lo) begin
          arr_wd = val;
        end
      end
      S_CVRD: begin
        arr_ra = idx[AW-1:0];
        bmp_ra = cv_val[15:BW];
      end
      S_CVBR: bmp_ra = arr_q[15:BW];
      S_CVBW: begin
        bmp_we = 1'b1;
        bmp_wa = cv_val[15:BW];
        bmp_wd = bmp_q | (WordBits'(1) << cv_val[BW-1:0]);
      end
      S_BWR: bmp_we = (cmd == CMD_ADD);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      mode  <= 1'b0;
      count <= '0;
      idx   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx[WW-1:0] == WW'(BitmapWords - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            cmd <= req.cmd;
            val <= req.value;
            lo  <= '0;
            hi  <= (count > CW'(ArrayDepth)) ? (AW+1)'(ArrayDepth) : count[AW:0];
            state <= mode ? S_BRD : S_SRD;
          end
        end
        S_SRD: state <= (lo < hi) ? S_SCMP : S_CHK;
        S_SCMP: begin
          if (arr_q < val) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_SRD;
        end
        S_CHK: state <= S_DEC;
        S_DEC: begin
          present <= hit;
          state   <= S_OUT;
          if (!hit && cmd == CMD_ADD) begin
            if (count >= CW'(ArrayLimit)) begin
              idx   <= '0;
              state <= S_CVRD;
            end else begin
              idx   <= count[AW:0];
              state <= (count[AW:0] == lo) ? S_SHWR : S_SHRD;
              count <= count + 1'b1;
            end
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          if (idx == lo) begin
            state <= S_OUT;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_SHRD;
          end
        end
        S_CVRD: state <= S_CVBR;
        S_CVBR: begin
          cv_val <= arr_q;
          state  <= S_CVBW;
        end
        S_CVBW: begin
          if (idx == (AW+1)'(ArrayLimit - 1)) begin
            mode  <= 1'b1;
            state <= S_BRD;
            cmd   <= CMD_ADD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CVRD;
          end
        end
        S_BRD: state <= S_BWR;
        S_BWR: begin
          if (!bmp_q[val[BW-1:0]] && cmd == CMD_ADD) begin
            count <= count + 1'b1;
          end
          present <= bmp_q[val[BW-1:0]];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/hybrid_set_container_insert_query.sv -----
// Top level: hybrid sorted-array / bitmap set with add and query transactions.
//  channel | handshake    | payload
//  input   | push / full  | in_data  (cmd, value)
//  result  | empty / pop  | out_data (was_present, bitmap_mode, member_total)
// Query or duplicate in array form: a binary search with one array read per search step.
// New value in array form: search plus insert shifting, a read and a write per moved entry.
// Conversion at the limit: each array entry is read and set in the bitmap, once.
// After reset the bitmap is cleared word by word; the input queue takes two, then full.
// Input and result queues hold two transactions each so both sides can stall.
`timescale 1ns / 1ps
module hybrid_set_container_insert_query (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hsc_pkg::in_item_t  in_data,
  output logic               full,
  input  logic               pop,
  output hsc_pkg::out_item_t out_data,
  output logic               empty
);
  import hsc_pkg::*;

  in_item_t  q_item;
  logic      q_empty;
  logic      take;
  out_item_t res;
  logic      res_valid;
  logic      res_full;

  hsc_fifo #(.W($bits(in_item_t))) u_inq (
    .clk(clk), .rst(rst), .push(push), .din(in_data), .full(full),
    .pop(take), .dout(q_item), .empty(q_empty)
  );

  hsc_engine u_eng (
    .clk(clk), .rst(rst), .req_valid(!q_empty), .req(q_item), .req_take(take),
    .res_valid(res_valid), .res(res), .res_full(res_full)
  );

  hsc_fifo #(.W($bits(out_item_t))) u_outq (
    .clk(clk), .rst(rst), .push(res_valid), .din(res), .full(res_full),
    .pop(pop), .dout(out_data), .empty(empty)
  );
endmodule
